// File: hdl/rgfp_pkg.sv
// Package for the RGB grayscale frame packer.
// Holds request and result types, field widths and status codes.
// Used by every module of the block and by its checker.
package rgfp_pkg;

	localparam int LED_W   = 3;
	localparam int LEVEL_W = 12;
	localparam int BYTE_W  = 8;
	// Width of the intermediate write channel sum 3*led + offset. One bit of
	// headroom lets it be compared against the channel count of the largest frame.
	localparam int WSUM_W  = 6;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef struct packed {
		logic [LED_W-1:0]   led_index;
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              last_byte;
		logic              status;
	} res_t;

	// Port commands from the sequencer to the level store.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_cmd_t;

endpackage

// File: hdl/rgfp_store.sv
// Grayscale level store: one synchronous memory with a registered read port.
// Per-entry valid bits make never-written entries read as zero after reset.
// Depends on rgfp_pkg.
module rgfp_store import rgfp_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  store_cmd_t         cmd,
	input  logic [AW-1:0]      waddr,
	input  logic [LEVEL_W-1:0] wdata,
	input  logic [AW-1:0]      raddr,
	output logic [LEVEL_W-1:0] rdata
);

	logic [LEVEL_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   valid_q;
	logic [LEVEL_W-1:0] rdata_q;
	logic               rd_ok_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
			rd_ok_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr_en) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// An entry that was never written since reset reads as level zero.
	assign rdata = rd_ok_q ? rdata_q : '0;

endmodule

// File: hdl/rgfp_seq.sv
// Sequencer of the frame packer: writes the three levels of a request, then
// walks the store from the top channel down and packs one byte per cycle.
// Depends on rgfp_pkg; drives the ports of rgfp_store.
module rgfp_seq import rgfp_pkg::*; #(
	parameter int FRAME_BYTES   = 24,
	parameter int MAX_LED_INDEX = 4,
	parameter int NUM_CH        = 16,
	parameter int NG            = 8,
	parameter int GW            = 3,
	parameter int AW            = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  req_t               request,
	output logic               strobe,
	output res_t               result,
	output store_cmd_t         cmd,
	output logic [AW-1:0]      waddr,
	output logic [LEVEL_W-1:0] wdata,
	output logic [AW-1:0]      raddr,
	input  logic [LEVEL_W-1:0] rdata
);

	// Bytes of the top group of three that lie inside the frame.
	localparam int TOP_BYTES = FRAME_BYTES - 3 * (NG - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WRITE = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;

	// Byte position within a group of three bytes (two channels).
	localparam logic [1:0] PH_LOW  = 2'd0;
	localparam logic [1:0] PH_MID  = 2'd1;
	localparam logic [1:0] PH_HIGH = 2'd2;

	logic [1:0]         state_q;
	logic [1:0]         wcnt_q;
	req_t               req_q;
	logic [GW-1:0]      grp_q;
	logic [1:0]         phase_q;
	logic               vld_s1;
	logic [1:0]         phase_s1;
	logic               emit_s1;
	logic               last_s1;
	logic [LEVEL_W-1:0] hold_q;
	logic               strobe_q;
	res_t               result_q;

	logic               accept;
	logic               bad_index;
	logic [WSUM_W-1:0]  wsum;
	logic               emit;
	logic [BYTE_W-1:0]  packed_byte;

	assign accept    = start && !busy;
	assign bad_index = request.led_index > LED_W'(MAX_LED_INDEX);
	assign busy      = (state_q != ST_IDLE) || vld_s1;

	assign wsum  = WSUM_W'({req_q.led_index, 1'b0}) + WSUM_W'(req_q.led_index)
		+ WSUM_W'(wcnt_q);
	assign waddr = wsum[AW-1:0];
	assign raddr = {grp_q, phase_q[1]};

	always_comb begin
		unique case (wcnt_q)
			2'd0:    wdata = req_q.red_level;
			2'd1:    wdata = req_q.green_level;
			default: wdata = req_q.blue_level;
		endcase
	end

	assign cmd.wr_en = (state_q == ST_WRITE) && (wsum < WSUM_W'(NUM_CH));
	assign cmd.rd_en = (state_q == ST_READ) && (phase_q != PH_LOW);

	assign emit = (grp_q != GW'(NG - 1)) || (phase_q < 2'(TOP_BYTES));

	// Byte 3k+2 is channel 2k+1 bits 11..4, byte 3k+1 joins channel 2k+1 bits
	// 3..0 with channel 2k bits 11..8, byte 3k is channel 2k bits 7..0.
	always_comb begin
		unique case (phase_s1)
			PH_HIGH: packed_byte = rdata[11:4];
			PH_MID:  packed_byte = {hold_q[3:0], rdata[11:8]};
			default: packed_byte = hold_q[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wcnt_q   <= '0;
			grp_q    <= '0;
			phase_q  <= PH_HIGH;
			vld_s1   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			vld_s1   <= 1'b0;
			strobe_q <= vld_s1 && emit_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (bad_index) begin
							strobe_q <= 1'b1;
						end else begin
							state_q <= ST_WRITE;
							wcnt_q  <= '0;
						end
					end
				end
				ST_WRITE: begin
					wcnt_q <= wcnt_q + 2'd1;
					if (wcnt_q == 2'd2) begin
						state_q <= ST_READ;
						grp_q   <= GW'(NG - 1);
						phase_q <= PH_HIGH;
					end
				end
				ST_READ: begin
					vld_s1 <= 1'b1;
					if (phase_q == PH_LOW) begin
						phase_q <= PH_HIGH;
						grp_q   <= grp_q - GW'(1);
						if (grp_q == '0) begin
							state_q <= ST_IDLE;
						end
					end else begin
						phase_q <= phase_q - 2'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		phase_s1 <= phase_q;
		emit_s1  <= emit;
		last_s1  <= (grp_q == '0) && (phase_q == PH_LOW);
		if (vld_s1 && (phase_s1 != PH_LOW)) begin
			hold_q <= rdata;
		end
		if (accept && bad_index) begin
			result_q.frame_byte <= '0;
			result_q.last_byte  <= 1'b1;
			result_q.status     <= STATUS_RANGE;
		end else begin
			result_q.frame_byte <= packed_byte;
			result_q.last_byte  <= last_s1;
			result_q.status     <= STATUS_OK;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// File: hdl/rgb_grayscale_frame_packer.sv
// Top level of the RGB grayscale frame packer.
// Instantiates the sequencer rgfp_seq and the level store rgfp_store;
// types come from rgfp_pkg.
//
// Channel  | Handshake          | Payload | Direction
// ---------+--------------------+---------+----------
// request  | start high, busy low | req_t | in
// result   | strobe, one cycle  | res_t   | out
//
// A request with an LED index above MAX_LED_INDEX gives one error result in
// the cycle after it is accepted and leaves the store unchanged; busy stays
// low. A valid request first writes its red, green and blue levels to the
// store, then streams FRAME_BYTES bytes, highest byte first, one per cycle,
// with last_byte set on byte 0. A new request is taken only once the
// previous frame is done: busy stays high until its final byte is shown.
// The store has a write port and a registered read port. The receiver
// cannot stall: every result is shown for exactly one cycle. Reset clears
// the control state and the store's valid bits, so every channel reads as
// level zero until it is written.
module rgb_grayscale_frame_packer import rgfp_pkg::*; #(
	parameter int FRAME_BYTES   = 24,
	parameter int MAX_LED_INDEX = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic strobe,
	output res_t result
);

	// Channels covered by the frame, and groups of three bytes (two channels).
	localparam int NUM_CH = (FRAME_BYTES * 8 + LEVEL_W - 1) / LEVEL_W;
	localparam int NG     = (FRAME_BYTES + 2) / 3;
	localparam int GW     = (NG > 1) ? $clog2(NG) : 1;
	localparam int AW     = GW + 1;
	// The store is rounded up to whole groups; any entry beyond NUM_CH is never written.
	localparam int DEPTH  = 2 * NG;

	store_cmd_t         cmd;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	logic [LEVEL_W-1:0] wdata;
	logic [LEVEL_W-1:0] rdata;

	rgfp_seq #(
		.FRAME_BYTES  (FRAME_BYTES),
		.MAX_LED_INDEX(MAX_LED_INDEX),
		.NUM_CH       (NUM_CH),
		.NG           (NG),
		.GW           (GW),
		.AW           (AW)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.strobe (strobe),
		.result (result),
		.cmd    (cmd),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	rgfp_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

endmodule

// File: hdl/rgfp_checker.sv
// Port-level checker for the RGB grayscale frame packer, bound to the top.
// Depends on rgfp_pkg.
module rgfp_checker import rgfp_pkg::*; #(
	parameter int MAX_LED_INDEX = 4
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t request,
	input logic strobe,
	input res_t result
);

	logic bad_req;
	assign bad_req = start && !busy && (request.led_index > LED_W'(MAX_LED_INDEX));

	// A rejected index answers with exactly the error result in the next cycle.
	a_error_next: assert property (@(posedge clk) disable iff (!arst_n)
		bad_req |=> strobe && result.status == STATUS_RANGE && result.last_byte
			&& result.frame_byte == '0)
		else $error("rejected request did not give an error result");

	// A good request first updates the store, so no result follows at once.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !bad_req) |=> !strobe)
		else $error("result shown right after a good request");

	// Bytes of one frame come on consecutive cycles.
	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last_byte) |=> strobe && result.status == STATUS_OK)
		else $error("gap or status change inside a frame");

	// Once the final result is shown, the block takes a new request.
	a_idle_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last_byte) |-> !busy)
		else $error("busy still high with the final result");

endmodule

bind rgb_grayscale_frame_packer rgfp_checker #(
	.MAX_LED_INDEX(MAX_LED_INDEX)
) u_rgfp_checker (.*);

// File: bench/testbench.sv
// Self-checking bench for the RGB grayscale frame packer (rgb_grayscale_frame_packer).
// It predicts every byte of every packed frame and checks the DUT's results as they appear.
// Depends on rgfp_pkg for the request and result types and for the status codes.
module testbench;
	import rgfp_pkg::*;

	// Geometry of the packed frame at the default parameters.
	localparam int FRAME_BYTES   = 24;
	localparam int MAX_LED_INDEX = 4;
	localparam int NUM_CHANNELS  = (FRAME_BYTES * 8 + LEVEL_W - 1) / LEVEL_W;
	localparam int FRAME_BITS    = FRAME_BYTES * 8;

	// Even with long sender gaps the whole run stays far below this bound,
	// so hitting it means a hang.
	localparam int CYCLE_LIMIT   = 400000;
	// Cycles to wait after the last expected byte for any stray result.
	localparam int DRAIN_CYCLES  = 64;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic strobe;
	res_t result;

	rgb_grayscale_frame_packer #(
		.FRAME_BYTES  (FRAME_BYTES),
		.MAX_LED_INDEX(MAX_LED_INDEX)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.strobe (strobe),
		.result (result)
	);

	// Our own copy of the grayscale store, cleared as at reset.
	logic [LEVEL_W-1:0] level_store [NUM_CHANNELS];
	// Bytes still to come from the DUT, oldest first.
	res_t pending_bytes [$];

	int errors;
	int cycle_count;
	int requests_sent;
	int requests_rejected;
	int bytes_checked;
	// Chance in a hundred that the sender idles for a given cycle.
	int idle_pct;

	res_t want;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog: any hang ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Watchdog expired after %0d cycles with %0d bytes pending.",
				cycle_count, pending_bytes.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Updates the store for one accepted request and queues the bytes that
	// the packer should emit for it. An index above the limit leaves the
	// store alone and yields a single error result.
	task automatic predict_frame(input req_t item);
		logic [FRAME_BITS-1:0] frame_word;
		res_t r;
		int base;
		if (item.led_index > MAX_LED_INDEX) begin
			r.frame_byte = '0;
			r.last_byte  = 1'b1;
			r.status     = STATUS_RANGE;
			pending_bytes.push_back(r);
			requests_rejected++;
			return;
		end
		base = item.led_index * 3;
		if (base < NUM_CHANNELS)     level_store[base]     = item.red_level;
		if (base + 1 < NUM_CHANNELS) level_store[base + 1] = item.green_level;
		if (base + 2 < NUM_CHANNELS) level_store[base + 2] = item.blue_level;
		// Channel c occupies bits 12c..12c+11 of the frame word, little-endian.
		frame_word = '0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (c * LEVEL_W + LEVEL_W <= FRAME_BITS)
				frame_word[c * LEVEL_W +: LEVEL_W] = level_store[c];
		end
		// Bytes leave from the top of the word down to byte 0.
		for (int b = FRAME_BYTES - 1; b >= 0; b--) begin
			r.frame_byte = frame_word[b * 8 +: 8];
			r.last_byte  = (b == 0);
			r.status     = STATUS_OK;
			pending_bytes.push_back(r);
		end
	endtask

	// Result checker. Outputs are sampled at the rising edge, before the
	// DUT's own updates for that edge take effect.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_bytes.size() == 0) begin
				$error("unexpected result: frame_byte %h last_byte %b status %b",
					result.frame_byte, result.last_byte, result.status);
				errors++;
			end else begin
				want = pending_bytes.pop_front();
				bytes_checked++;
				if (result.frame_byte !== want.frame_byte) begin
					$error("frame_byte: expected %h, actual %h",
						want.frame_byte, result.frame_byte);
					errors++;
				end
				if (result.last_byte !== want.last_byte) begin
					$error("last_byte: expected %b, actual %b",
						want.last_byte, result.last_byte);
					errors++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %b, actual %b", want.status, result.status);
					errors++;
				end
			end
		end
	end

	// Sends one request. Inputs change only at the falling edge. The sender
	// may first sit idle with start low, staying idle on each cycle with chance
	// idle_pct; start is then raised with the payload and held until a rising
	// edge sees start high and busy low. Start is left high on return, so a
	// back-to-back request keeps it high without dropping it in between.
	task automatic send_request(input req_t item);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start   <= 1'b0;
			request <= '0;
		end
		@(negedge clk);
		start   <= 1'b1;
		request <= item;
		do @(posedge clk); while (busy !== 1'b0);
		predict_frame(item);
		requests_sent++;
	endtask

	function automatic req_t make_request(input logic [LED_W-1:0] led,
		input logic [LEVEL_W-1:0] red, input logic [LEVEL_W-1:0] green,
		input logic [LEVEL_W-1:0] blue);
		req_t r;
		r.led_index   = led;
		r.red_level   = red;
		r.green_level = green;
		r.blue_level  = blue;
		return r;
	endfunction

	// Levels lean toward the extremes and single bits, so that every
	// boundary between channels inside a byte gets exercised.
	function automatic logic [LEVEL_W-1:0] random_level();
		logic [LEVEL_W-1:0] v;
		case ($urandom_range(7))
			0: begin
				v = '0;
			end
			1: begin
				v = '1;
			end
			2: begin
				v = '0;
				v[$urandom_range(LEVEL_W - 1)] = 1'b1;
			end
			default: begin
				v = LEVEL_W'($urandom_range(4095));
			end
		endcase
		return v;
	endfunction

	// Most requests name a valid LED; about one in seven is out of range.
	function automatic req_t random_request();
		logic [LED_W-1:0] led;
		if ($urandom_range(6) == 0)
			led = LED_W'($urandom_range(7, MAX_LED_INDEX + 1));
		else
			led = LED_W'($urandom_range(MAX_LED_INDEX));
		return make_request(led, random_level(), random_level(), random_level());
	endfunction

	// A fresh store packs to all zeros; a rejected request before any
	// write must not disturb that.
	task automatic test_cleared_store();
		send_request(make_request(3'd7, 12'hFFF, 12'hFFF, 12'hFFF));
		send_request(make_request(3'd0, 12'h000, 12'h000, 12'h000));
	endtask

	// Full-scale levels on every LED position, then zero levels on LED 2 and patterned levels on LEDs 4, 0 and 1.
	task automatic test_level_extremes();
		for (int led = 0; led <= MAX_LED_INDEX; led++)
			send_request(make_request(LED_W'(led), 12'hFFF, 12'hFFF, 12'hFFF));
		send_request(make_request(3'd2, 12'h000, 12'h000, 12'h000));
		send_request(make_request(3'd4, 12'h800, 12'h001, 12'hA5A));
		send_request(make_request(3'd0, 12'h555, 12'hAAA, 12'h0F0));
		send_request(make_request(3'd1, 12'h001, 12'h800, 12'hFFF));
	endtask

	// Every rejected index, back to back, then a valid request that shows
	// the store was left as it was.
	task automatic test_index_out_of_range();
		for (int led = MAX_LED_INDEX + 1; led < 8; led++)
			send_request(make_request(LED_W'(led), 12'h123, 12'h456, 12'h789));
		send_request(make_request(3'd7, 12'h000, 12'hFFF, 12'h000));
		send_request(make_request(3'd3, 12'h3C3, 12'hC3C, 12'h00F));
	endtask

	// The channel past the last LED is never written and must stay zero,
	// even with the neighboring LED at full scale.
	task automatic test_unused_channel();
		send_request(make_request(LED_W'(MAX_LED_INDEX), 12'hFFF, 12'hFFF, 12'hFFF));
		send_request(make_request(LED_W'(MAX_LED_INDEX), 12'h000, 12'h000, 12'hFFF));
	endtask

	task automatic test_random_requests(input int count, input int pct);
		idle_pct = pct;
		repeat (count) send_request(random_request());
		idle_pct = 0;
	endtask

	initial begin
		errors            = 0;
		cycle_count       = 0;
		requests_sent     = 0;
		requests_rejected = 0;
		bytes_checked     = 0;
		idle_pct          = 0;
		for (int c = 0; c < NUM_CHANNELS; c++)
			level_store[c] = '0;
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		test_cleared_store();
		test_level_extremes();
		test_index_out_of_range();
		test_unused_channel();
		// Random phases: no sender gaps, mostly idle, then lightly idle.
		test_random_requests(90, 0);
		test_random_requests(90, 69);
		test_random_requests(90, 18);

		@(negedge clk);
		start   <= 1'b0;
		request <= '0;

		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests, %0d of them with an out-of-range LED index.",
			requests_sent, requests_rejected);
		$display("Checked %0d result bytes across all sender idle phases.", bytes_checked);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
